/* rtl/rcu_gpd_pkg.sv */
// types and constants shared by the grace-period detector modules
// no dependencies

package rcu_gpd_pkg;

    localparam int NUM_CPUS_DEF    = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_W           = 8;
    localparam int CPU_W           = 3;
    localparam int OP_W            = 2;
    localparam int FLIP_W          = 32;
    localparam int S_DATA_W        = 8;
    localparam int M_DATA_W        = 40;

    typedef enum logic [OP_W-1:0] {
        OP_LOCK   = 2'd0,
        OP_UNLOCK = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CPU_W-1:0] cpu;
        logic             unlock_index;
        logic             callbacks_queued;
    } item_t;

    // packed so that lock_index sits in bit 0
    typedef struct packed {
        logic [FLIP_W-1:0] completed_count;
        logic [1:0]        phase_state;
        logic              advance_callbacks;
        logic              lock_index;
    } result_t;

endpackage

/* rtl/rcu_gpd_core.sv */
// detector state and per-word update logic of the grace-period detector
// depends on rcu_gpd_pkg

module rcu_gpd_core #(
    parameter int NUM_CPUS    = rcu_gpd_pkg::NUM_CPUS_DEF,
    parameter int COUNT_WIDTH = rcu_gpd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  rcu_gpd_pkg::item_t            item,
    input  logic [rcu_gpd_pkg::CFG_W-1:0] online,
    output rcu_gpd_pkg::result_t          result
);

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_WAITACK  = 2'd1,
        ST_WAITZERO = 2'd2,
        ST_WAITMB   = 2'd3
    } state_t;

    state_t                                 state_reg, state_next;
    logic [rcu_gpd_pkg::FLIP_W-1:0]         flip_reg, flip_next;
    logic [NUM_CPUS-1:0]                    ack_reg, ack_next;
    logic [NUM_CPUS-1:0]                    barrier_reg, barrier_next;
    logic [NUM_CPUS-1:0]                    behind_reg, behind_next;
    // per-cpu reader counts only ever enter the zero test as a per-phase sum,
    // so each phase keeps its running total modulo 2^COUNT_WIDTH
    logic [COUNT_WIDTH-1:0]                 sum0_reg, sum0_next;
    logic [COUNT_WIDTH-1:0]                 sum1_reg, sum1_next;

    logic [NUM_CPUS-1:0] online_mask;
    logic                cpu_ok;
    logic [NUM_CPUS-1:0] cpu_bit;
    logic [NUM_CPUS-1:0] bp_clr;
    logic                old_zero;
    logic                lock_idx;
    logic                adv;

    // register bits above the cpu count are ignored
    for (genvar i = 0; i < NUM_CPUS; i++) begin : g_online
        if (i < rcu_gpd_pkg::CFG_W) begin : g_in
            assign online_mask[i] = online[i];
        end else begin : g_out
            assign online_mask[i] = 1'b0;
        end
    end

    assign cpu_ok   = (int'(item.cpu) < NUM_CPUS);
    assign cpu_bit  = cpu_ok ? (NUM_CPUS'(1) << item.cpu) : '0;
    assign bp_clr   = barrier_reg & ~cpu_bit;
    assign old_zero = flip_reg[0] ? (sum0_reg == '0) : (sum1_reg == '0);

    always_comb
    begin
        state_next   = state_reg;
        flip_next    = flip_reg;
        ack_next     = ack_reg;
        barrier_next = barrier_reg;
        behind_next  = behind_reg;
        sum0_next    = sum0_reg;
        sum1_next    = sum1_reg;
        lock_idx     = 1'b0;
        adv          = 1'b0;
        if (cpu_ok)
        begin
            case (item.op)
                rcu_gpd_pkg::OP_LOCK:
                begin
                    lock_idx = flip_reg[0];
                    if (flip_reg[0])
                        sum1_next = sum1_reg + COUNT_WIDTH'(1);
                    else
                        sum0_next = sum0_reg + COUNT_WIDTH'(1);
                end
                rcu_gpd_pkg::OP_UNLOCK:
                begin
                    if (item.unlock_index)
                        sum1_next = sum1_reg - COUNT_WIDTH'(1);
                    else
                        sum0_next = sum0_reg - COUNT_WIDTH'(1);
                end
                rcu_gpd_pkg::OP_TICK:
                begin
                    barrier_next = bp_clr;
                    if ((behind_reg & cpu_bit) == '0)
                    begin
                        unique case (state_reg)
                            ST_IDLE:
                            begin
                                // barrier and behind terms are already clear here
                                if (item.callbacks_queued || ((ack_reg & cpu_bit) != '0))
                                begin
                                    flip_next   = flip_reg + 32'd1;
                                    ack_next    = ack_reg | online_mask;
                                    behind_next = '1;
                                    state_next  = ST_WAITACK;
                                end
                            end
                            ST_WAITACK:
                            begin
                                if ((ack_reg & online_mask) == '0)
                                    state_next = ST_WAITZERO;
                            end
                            ST_WAITZERO:
                            begin
                                if (old_zero)
                                begin
                                    barrier_next = bp_clr | online_mask;
                                    state_next   = ST_WAITMB;
                                end
                            end
                            ST_WAITMB:
                            begin
                                if ((bp_clr & online_mask) == '0)
                                    state_next = ST_IDLE;
                            end
                            default: state_next = ST_IDLE;
                        endcase
                    end
                    // catch up with the latest flip and acknowledge it
                    if ((behind_next & cpu_bit) != '0)
                        adv = 1'b1;
                    behind_next = behind_next & ~cpu_bit;
                    ack_next    = ack_next & ~cpu_bit;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            flip_reg    <= '0;
            ack_reg     <= '0;
            barrier_reg <= '0;
            behind_reg  <= '0;
            sum0_reg    <= '0;
            sum1_reg    <= '0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            flip_reg    <= flip_next;
            ack_reg     <= ack_next;
            barrier_reg <= barrier_next;
            behind_reg  <= behind_next;
            sum0_reg    <= sum0_next;
            sum1_reg    <= sum1_next;
        end
    end

    assign result.lock_index        = lock_idx;
    assign result.advance_callbacks = adv;
    assign result.phase_state       = state_next;
    assign result.completed_count   = flip_next;

endmodule

/* rtl/rcu_grace_period_detector_unit.sv */
// top level of the counter-flip grace-period detector: input, output and config registers
// depends on rcu_gpd_pkg and rcu_gpd_core

// usage
// - slave stream carries one event word: s_tuser is the event kind (lock, unlock, tick),
//   s_tdata the cpu number, unlock phase and callbacks-queued flag
// - master stream returns exactly one result word per event, in order
// - cfg channel writes the online cpu mask; always ready, write only while idle
// flow and throughput
// - an event accepted into the input register is processed by the detector logic once
//   the result register is free or being drained, and is then shown on m_tvalid
// - one event per cycle sustained while m_tready stays high; the detector state updates as
//   each event is processed, so back-to-back events see each other's effects
// stalls
// - when m_tready is low the result word holds and the input register still takes
//   one more event; s_tready drops only once both registers are full
// reset
// - rst_n clears the detector to idle, zero flips, zero reader totals, no pending
//   acks or barriers, online mask zero and both registers empty

module rcu_grace_period_detector_unit #(
    parameter int NUM_CPUS    = rcu_gpd_pkg::NUM_CPUS_DEF,
    parameter int COUNT_WIDTH = rcu_gpd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] cpu, [3] unlock_index, [4] callbacks_queued, [7:5] zero
    input  logic [rcu_gpd_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] op
    input  logic [rcu_gpd_pkg::OP_W-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] lock_index, [1] advance_callbacks, [3:2] phase_state, [35:4] completed_count,
    // [39:36] zero
    output logic [rcu_gpd_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcu_gpd_pkg::CFG_W-1:0]    cfg_data
);

    logic                          in_valid_reg, in_valid_next;
    rcu_gpd_pkg::item_t            in_item_reg;
    logic                          out_valid_reg, out_valid_next;
    rcu_gpd_pkg::result_t          out_reg;
    logic [rcu_gpd_pkg::CFG_W-1:0] online_reg;

    rcu_gpd_pkg::item_t   s_item;
    rcu_gpd_pkg::result_t core_result;
    logic                 advance;
    logic                 fire;

    // unpack the incoming word
    assign s_item.op               = rcu_gpd_pkg::op_t'(s_tuser);
    assign s_item.cpu              = s_tdata[rcu_gpd_pkg::CPU_W-1:0];
    assign s_item.unlock_index     = s_tdata[rcu_gpd_pkg::CPU_W];
    assign s_item.callbacks_queued = s_tdata[rcu_gpd_pkg::CPU_W+1];

    // output register free or being drained this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            online_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                online_reg <= cfg_data;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= s_item;
        if (fire)
            out_reg <= core_result;
    end

    rcu_gpd_core #(
        .NUM_CPUS    (NUM_CPUS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .online (online_reg),
        .result (core_result)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = rcu_gpd_pkg::M_DATA_W'(out_reg);

`ifndef SYNTH
    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // a lock phase is only reported for lock events
    a_lock_only_on_lock: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_item_reg.op != rcu_gpd_pkg::OP_LOCK) |-> !core_result.lock_index)
        else $error("lock index set for a non-lock event");

    // catching up only happens on a tick
    a_adv_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && core_result.advance_callbacks |-> in_item_reg.op == rcu_gpd_pkg::OP_TICK)
        else $error("advance reported for a non-tick event");

    // a processed event lands in the result register at the next edge
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed event produced no result word");
`endif

endmodule

/* tb/tb_rcu_grace_period_detector_unit.sv */
// self-checking testbench for rcu_grace_period_detector_unit: directed and random event streams
// checked against an in-bench model of the counter-flip grace-period detector
// depends on rcu_gpd_pkg and the rcu_grace_period_detector_unit rtl
`timescale 1ns / 1ps

module tb_rcu_grace_period_detector_unit;

    localparam int NCPU     = rcu_gpd_pkg::NUM_CPUS_DEF;
    localparam int CNT_W    = rcu_gpd_pkg::COUNT_WIDTH_DEF;
    localparam int OP_W     = rcu_gpd_pkg::OP_W;
    localparam int CPU_W    = rcu_gpd_pkg::CPU_W;
    localparam int CFG_W    = rcu_gpd_pkg::CFG_W;
    localparam int FLIP_W   = rcu_gpd_pkg::FLIP_W;
    localparam int S_DATA_W = rcu_gpd_pkg::S_DATA_W;
    localparam int M_DATA_W = rcu_gpd_pkg::M_DATA_W;

    // op code the block leaves unused, not part of op_t
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // detector states as shown in phase_state
    localparam logic [1:0] GP_IDLE     = 2'd0;
    localparam logic [1:0] GP_WAITACK  = 2'd1;
    localparam logic [1:0] GP_WAITZERO = 2'd2;
    localparam logic [1:0] GP_WAITMB   = 2'd3;

    localparam int DRAIN_CYCLES = 4;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // [2:0] cpu, [3] unlock_index, [4] callbacks_queued, [7:5] zero
    logic [S_DATA_W-1:0] s_tdata   = '0;
    // [1:0] op
    logic [OP_W-1:0]     s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // [0] lock_index, [1] advance_callbacks, [3:2] phase_state, [35:4] completed_count
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // detector model state, updated as each event word is accepted
    logic [CNT_W-1:0]    reader_total [2*NCPU];
    logic [NCPU-1:0]     ack_wait;
    logic [NCPU-1:0]     mb_wait;
    logic [NCPU-1:0]     behind_mask;
    logic [NCPU-1:0]     online_mask;
    logic [1:0]          gp_state;
    logic [FLIP_W-1:0]   flip_total;

    rcu_gpd_pkg::result_t expected_results [$];
    // phases of read locks still held by the random stream
    logic                held_phase [$];
    int                  mismatches = 0;
    bit                  sender_burst = 1'b0;

    rcu_grace_period_detector_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [CPU_W-1:0] rand_cpu();
        return CPU_W'($urandom_range(0, (1 << CPU_W) - 1));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // model of one event: updates the state and returns the result word it causes
    function automatic rcu_gpd_pkg::result_t predict_event(input logic [OP_W-1:0] op,
                                                           input logic [CPU_W-1:0] cpu,
                                                           input logic uidx,
                                                           input logic cbq);
        rcu_gpd_pkg::result_t res;
        int                   base;
        logic                 old_phase;
        logic [CNT_W-1:0]     old_sum;
        res  = '0;
        base = 2 * int'(cpu);
        if (int'(cpu) < NCPU)
        begin
            if (op == rcu_gpd_pkg::OP_LOCK)
            begin
                res.lock_index = flip_total[0];
                reader_total[base + flip_total[0]] += 1'b1;
            end
            else if (op == rcu_gpd_pkg::OP_UNLOCK)
            begin
                reader_total[base + uidx] -= 1'b1;
            end
            else if (op == rcu_gpd_pkg::OP_TICK)
            begin
                // a tick always answers a barrier request first
                mb_wait[cpu] = 1'b0;
                if (!behind_mask[cpu])
                begin
                    case (gp_state)
                        GP_IDLE:
                        begin
                            if (cbq || ack_wait[cpu] || mb_wait[cpu])
                            begin
                                flip_total  = flip_total + 1'b1;
                                ack_wait    = ack_wait | online_mask;
                                behind_mask = '1;
                                gp_state    = GP_WAITACK;
                            end
                        end
                        GP_WAITACK:
                        begin
                            if ((ack_wait & online_mask) == '0)
                                gp_state = GP_WAITZERO;
                        end
                        GP_WAITZERO:
                        begin
                            // readers of the old phase, summed over all cpus with wrap
                            old_phase = ~flip_total[0];
                            old_sum   = '0;
                            for (int c = 0; c < NCPU; c++)
                                old_sum += reader_total[2*c + old_phase];
                            if (old_sum == '0)
                            begin
                                mb_wait  = mb_wait | online_mask;
                                gp_state = GP_WAITMB;
                            end
                        end
                        GP_WAITMB:
                        begin
                            if ((mb_wait & online_mask) == '0)
                                gp_state = GP_IDLE;
                        end
                    endcase
                end
                // catch up with the latest flip
                if (behind_mask[cpu])
                begin
                    res.advance_callbacks = 1'b1;
                    behind_mask[cpu]      = 1'b0;
                end
                ack_wait[cpu] = 1'b0;
            end
        end
        res.phase_state     = gp_state;
        res.completed_count = flip_total;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input rcu_gpd_pkg::result_t want,
                                   input rcu_gpd_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected lock=%0d adv=%0d state=%0d count=%0d,",
                      " got lock=%0d adv=%0d state=%0d count=%0d"},
                     $realtime, what, want.lock_index, want.advance_callbacks,
                     want.phase_state, want.completed_count, got.lock_index,
                     got.advance_callbacks, got.phase_state, got.completed_count);
    endtask

    // result side: compare each accepted word, then pick the next ready level
    int stall_left = 0;
    bit rx_burst   = 1'b0;

    always @(posedge clk)
    begin
        rcu_gpd_pkg::result_t got;
        rcu_gpd_pkg::result_t want;
        int                   r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(rcu_gpd_pkg::result_t)-1:0];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result word with none expected", '0, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.lock_index != want.lock_index
                        || got.advance_callbacks != want.advance_callbacks
                        || got.phase_state != want.phase_state
                        || got.completed_count != want.completed_count)
                        report_mismatch("result word mismatch", want, got);
                end
            end
            // occasional stretches of full-rate draining
            if ($urandom_range(0, 199) == 0)
                rx_burst = !rx_burst;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_burst)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    m_tready <= 1'b1;
                end
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // random gap after an accepted word; leaves s_tvalid high when there is none
    task automatic pause_sender();
        int r;
        int gap;
        if ($urandom_range(0, 99) < 3)
            sender_burst = !sender_burst;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!sender_burst)
        begin
            if (r >= 90)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drive one event word, wait for its handshake and record its expected result
    task automatic send_event(input logic [OP_W-1:0] op, input logic [CPU_W-1:0] cpu,
                              input logic uidx, input logic cbq, input bit keep = 1'b0);
        rcu_gpd_pkg::result_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, cbq, uidx, cpu};
        do
            @(posedge clk);
        while (!s_tready);
        res = predict_event(op, cpu, uidx, cbq);
        expected_results.push_back(res);
        if (keep && op == rcu_gpd_pkg::OP_LOCK)
            held_phase.push_back(res.lock_index);
        pause_sender();
    endtask

    // write the online mask once every expected word has come back
    task automatic set_online(input logic [CFG_W-1:0] mask);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        do
            @(posedge clk);
        while (!cfg_ready);
        online_mask = mask;
        cfg_valid <= 1'b0;
    endtask

    // unused op, a tick that has no reason to flip, a balanced lock and unlock
    task automatic test_unused_op_and_quiet_tick();
        send_event(OP_RESERVED,             3'd7, 1'b1, 1'b1);
        send_event(rcu_gpd_pkg::OP_TICK,    3'd0, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_LOCK,    3'd0, 1'b1, 1'b1);
        send_event(rcu_gpd_pkg::OP_UNLOCK,  3'd0, 1'b0, 1'b0);
    endtask

    // per-cpu counters going below zero and back, and a reader that moved cpus
    task automatic test_counter_wrap();
        send_event(rcu_gpd_pkg::OP_UNLOCK, 3'd7, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_LOCK,   3'd7, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_UNLOCK, 3'd1, 1'b0, 1'b1);
        send_event(rcu_gpd_pkg::OP_LOCK,   3'd6, 1'b1, 1'b0);
    endtask

    // two flips with cpus 0 and 7 online, the second held up by a reader of the old phase
    task automatic test_grace_period();
        set_online(8'h81);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd3, 1'b0, 1'b1);
        send_event(rcu_gpd_pkg::OP_LOCK,   3'd2, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd0, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd7, 1'b1, 1'b1);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd3, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd3, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd0, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd7, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd1, 1'b0, 1'b1);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd1, 1'b0, 1'b1);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd0, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd7, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd0, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd0, 1'b0, 1'b0);
        send_event(rcu_gpd_pkg::OP_UNLOCK, 3'd5, 1'b1, 1'b0);
        send_event(rcu_gpd_pkg::OP_TICK,   3'd0, 1'b0, 1'b0);
    endtask

    // mostly balanced reader traffic and ticks, with some noise and broken pairs
    task automatic test_random(input logic [CFG_W-1:0] mask, input int count);
        int   r;
        int   k;
        logic ph;
        set_online(mask);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                send_event(OP_RESERVED, rand_cpu(), rand_bit(), rand_bit());
            end
            else if (r < 11)
            begin
                // unlock before its lock, both in the current phase, on random cpus
                send_event(rcu_gpd_pkg::OP_UNLOCK, rand_cpu(), flip_total[0], rand_bit());
                send_event(rcu_gpd_pkg::OP_LOCK, rand_cpu(), rand_bit(), rand_bit());
            end
            else if (r < 45)
            begin
                send_event(rcu_gpd_pkg::OP_TICK, rand_cpu(), rand_bit(), rand_bit());
            end
            else if (held_phase.size() == 0 || (r < 72 && held_phase.size() < 6))
            begin
                send_event(rcu_gpd_pkg::OP_LOCK, rand_cpu(), rand_bit(), rand_bit(), 1'b1);
            end
            else
            begin
                // release a held reader, possibly from another cpu
                k  = $urandom_range(0, held_phase.size() - 1);
                ph = held_phase[k];
                held_phase.delete(k);
                send_event(rcu_gpd_pkg::OP_UNLOCK, rand_cpu(), ph, rand_bit());
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] mixed_mask;
        for (int i = 0; i < 2*NCPU; i++)
            reader_total[i] = '0;
        ack_wait    = '0;
        mb_wait     = '0;
        behind_mask = '0;
        online_mask = '0;
        gp_state    = GP_IDLE;
        flip_total  = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unused_op_and_quiet_tick();
        test_counter_wrap();
        test_grace_period();
        test_random(8'hFF, 150);
        test_random(8'h00, 100);
        test_random(8'h01, 100);
        mixed_mask = CFG_W'($urandom_range(1, 254));
        test_random(mixed_mask, 150);
        test_random(8'hFF, 100);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
